>>> design/trbe_pkg.sv
// ----------------------------------------------------------------------------
// trbe_pkg: shared types and constants of the timestamped ring buffer
// Depth, index widths, transaction payloads, stored entry and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package trbe_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  // Wide enough for head + count, which stays below 2 * DEPTH.
  localparam int SUM_W = IDX_W + 1;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_PURGE  = 1'b1
  } op_e;

  typedef enum logic {
    STATUS_OK   = 1'b0,
    STATUS_FULL = 1'b1
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_RESULT
  } state_e;

  typedef struct packed {
    op_e                op;
    logic signed [31:0] item_value;
    logic        [30:0] owner_tag;
    logic        [31:0] stamp;
  } in_t;

  typedef struct packed {
    status_e          status;
    logic [IDX_W-1:0] slot;
    logic [CNT_W-1:0] removed;
  } out_t;

  typedef struct packed {
    logic signed [31:0] item_value;
    logic        [30:0] owner_tag;
    logic        [31:0] stamp;
  } entry_t;

endpackage

`default_nettype wire

>>> design/trbe_ram.sv
// ----------------------------------------------------------------------------
// trbe_ram: single-port-write, single-port-read synchronous RAM
// One write and one read per cycle; read data is registered and appears in the cycle after the read.
// ----------------------------------------------------------------------------
`default_nettype none

module trbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> design/timestamped_ring_buffer_expiry.sv
// ----------------------------------------------------------------------------
// timestamped_ring_buffer_expiry: circular FIFO with age-based expiry
// Appends store value, owner and stamp in a ring; a purge drops head entries
// whose stamp is older than a cutoff and reports how many were dropped.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake               Payload
//  in       input      in_valid_i/in_ready_o   in_data_i  (trbe_pkg::in_t)
//  out      output     out_valid_o/out_ready_i out_data_o (trbe_pkg::out_t)
//
// An append writes the entry RAM in its accept cycle; S_RESULT then hands the
// result to the output register once that register is free. A purge walks
// the single RAM read port one head entry per cycle in S_CHECK until an entry
// is not expired or the FIFO empties; a purge of an empty FIFO goes straight
// to S_RESULT. Reset clears head, count and the output valid; RAM contents
// are not cleared. A stalled output holds one result while the next
// transaction is already being taken.
//
`default_nettype none

module timestamped_ring_buffer_expiry (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire trbe_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output trbe_pkg::out_t      out_data_o
);

  trbe_pkg::state_e               state_q, state_d;
  logic [trbe_pkg::IDX_W-1:0]     head_q, head_d;
  logic [trbe_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic [trbe_pkg::CNT_W-1:0]     rem_q, rem_d;
  logic [31:0]                    cutoff_q, cutoff_d;
  trbe_pkg::out_t                 res_q, res_d;
  logic                           out_valid_q, out_valid_d;
  trbe_pkg::out_t                 out_data_q, out_data_d;

  logic                           ram_we;
  logic                           ram_re;
  logic [trbe_pkg::IDX_W-1:0]     ram_raddr;
  logic [trbe_pkg::IDX_W-1:0]     wr_pos;
  logic [trbe_pkg::SUM_W-1:0]     pos_sum;
  logic [trbe_pkg::IDX_W-1:0]     head_inc;
  trbe_pkg::entry_t               wr_entry;
  logic [$bits(trbe_pkg::entry_t)-1:0] rd_bits;
  trbe_pkg::entry_t               rd_entry;

  // Tail slot is (head + count) mod DEPTH; the sum stays below 2 * DEPTH.
  always_comb begin
    pos_sum = trbe_pkg::SUM_W'(head_q) + trbe_pkg::SUM_W'(cnt_q);
    if (pos_sum >= trbe_pkg::SUM_W'(trbe_pkg::DEPTH)) begin
      pos_sum = pos_sum - trbe_pkg::SUM_W'(trbe_pkg::DEPTH);
    end
    wr_pos = pos_sum[trbe_pkg::IDX_W-1:0];
  end

  assign head_inc = (head_q == trbe_pkg::IDX_W'(trbe_pkg::DEPTH - 1)) ?
                    '0 : head_q + trbe_pkg::IDX_W'(1);

  assign wr_entry.item_value = in_data_i.item_value;
  assign wr_entry.owner_tag  = in_data_i.owner_tag;
  assign wr_entry.stamp      = in_data_i.stamp;
  assign rd_entry            = rd_bits;

  // Only one transaction is in flight, so a write and a read of the same
  // entry never overlap and no forwarding is needed.
  trbe_ram #(
    .WIDTH ($bits(trbe_pkg::entry_t)),
    .DEPTH (trbe_pkg::DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_pos),
    .wdata_i (wr_entry),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd_bits)
  );

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    cutoff_d    = cutoff_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    in_ready_o  = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = head_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      trbe_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          res_d         = '0;
          res_d.status  = trbe_pkg::STATUS_OK;
          if (in_data_i.op == trbe_pkg::OP_APPEND) begin
            if (cnt_q == trbe_pkg::CNT_W'(trbe_pkg::DEPTH)) begin
              res_d.status = trbe_pkg::STATUS_FULL;
            end else begin
              ram_we     = 1'b1;
              res_d.slot = wr_pos;
              cnt_d      = cnt_q + trbe_pkg::CNT_W'(1);
            end
            state_d = trbe_pkg::S_RESULT;
          end else begin
            cutoff_d = in_data_i.stamp;
            rem_d    = '0;
            if (cnt_q == '0) begin
              state_d = trbe_pkg::S_RESULT;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = head_q;
              state_d   = trbe_pkg::S_CHECK;
            end
          end
        end
      end

      trbe_pkg::S_CHECK: begin
        // The head entry read last cycle is on the RAM output now.
        if (rd_entry.stamp < cutoff_q) begin
          head_d = head_inc;
          cnt_d  = cnt_q - trbe_pkg::CNT_W'(1);
          rem_d  = rem_q + trbe_pkg::CNT_W'(1);
          if (cnt_q == trbe_pkg::CNT_W'(1)) begin
            res_d.removed = rem_q + trbe_pkg::CNT_W'(1);
            state_d       = trbe_pkg::S_RESULT;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = head_inc;
          end
        end else begin
          res_d.removed = rem_q;
          state_d       = trbe_pkg::S_RESULT;
        end
      end

      trbe_pkg::S_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = trbe_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = trbe_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= trbe_pkg::S_IDLE;
      head_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    cutoff_q   <= cutoff_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= trbe_pkg::CNT_W'(trbe_pkg::DEPTH))
    else $error("entry count exceeds depth");

  a_check_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == trbe_pkg::S_CHECK |-> cnt_q != '0)
    else $error("purge examines an empty FIFO");

  a_append_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_data_i.op == trbe_pkg::OP_APPEND &&
     cnt_q != trbe_pkg::CNT_W'(trbe_pkg::DEPTH))
    |=> cnt_q == $past(cnt_q) + trbe_pkg::CNT_W'(1))
    else $error("accepted append did not grow the FIFO");

  a_removed_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.removed <= trbe_pkg::CNT_W'(trbe_pkg::DEPTH))
    else $error("purge reports more entries than the depth");
`endif

endmodule

`default_nettype wire
